// ----- hw/rtl/shell_command_lexer_macros.svh -----
// ----------------------------------------------------------------------------
// shell command lexer assertion macros
// shared property wrappers clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LEXER_MACROS_SVH
`define SHELL_COMMAND_LEXER_MACROS_SVH

// implication checked on every rising edge outside reset
`define SCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// property that must hold in the cycle after a trigger
`define SCL_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/scl_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_pkg
// shared types, codes and character constants of the shell command lexer
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

  // lexer modes
  localparam logic [2:0] ModeStart   = 3'd0;
  localparam logic [2:0] ModeStartBs = 3'd1;
  localparam logic [2:0] ModeWord    = 3'd2;
  localparam logic [2:0] ModeWordBs  = 3'd3;
  localparam logic [2:0] ModeQuotes  = 3'd4;
  localparam logic [2:0] ModeOp      = 3'd5;
  localparam logic [2:0] ModeComment = 3'd6;

  // result kinds
  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindWordEnd = 2'd1;
  localparam logic [1:0] KindLineEnd = 2'd2;

  // characters
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChGt        = 8'h3e;
  localparam logic [7:0] ChPipe      = 8'h7c;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChLt        = 8'h3c;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChSemi      = 8'h3b;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0a;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic       at_eof;
  } result_t;

  // results of one item, in order
  typedef struct packed {
    logic    load;
    logic    two;
    result_t res0;
    result_t res1;
  } pair_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] b, logic eof);
    result_t r;
    r.kind       = kind;
    r.token_byte = b;
    r.at_eof     = eof;
    return r;
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return (c == ChGt) || (c == ChPipe) || (c == ChAmp) || (c == ChLt) ||
           (c == ChLParen) || (c == ChRParen) || (c == ChSemi);
  endfunction

  function automatic logic is_separator(logic [7:0] c);
    return (c == ChNewline) || (c == ChSpace) || (c == ChTab) || (c == ChQuote) ||
           (c == ChHash) || is_operator(c);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/shell_command_lexer.sv -----
// ----------------------------------------------------------------------------
// shell_command_lexer
// streaming shell tokenizer: one character or end of input in, byte,
// word-end and line-end results out
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_stall_o     char_code_i, end_of_input_i
// out       output     out_valid_o / out_stall_i   kind_o, token_byte_o, at_eof_o, last_o
//
// one input transfer per cycle unless stalled; input register feeds result register
// an item with two results holds the result register for two output transfers
// reset leaves the lexer between words with both registers empty
// in_stall_o rises when the input register holds an item and the result
// register still has results that are not taken this cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_command_lexer_macros.svh"

module shell_command_lexer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      token_byte_o,
  output logic            at_eof_o,
  output logic            last_o
);

  logic           in_valid_q;
  logic [7:0]     char_q;
  logic           eof_q;
  logic           free;
  logic           adv;
  logic           in_xfer;
  scl_pkg::pair_t pair;

  assign adv        = in_valid_q && free;
  assign in_stall_o = in_valid_q && !free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q <= char_code_i;
      eof_q  <= end_of_input_i;
    end
  end

  scl_lex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .char_i (char_q),
    .eof_i  (eof_q),
    .pair_o (pair)
  );

  scl_out_buf u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (adv && pair.load),
    .pair_i       (pair),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .token_byte_o (token_byte_o),
    .at_eof_o     (at_eof_o),
    .last_o       (last_o)
  );

  // a result that is not the last of its item is never a line end
  `SCL_ASSERT(a_first_not_line_end, (out_valid_o && !last_o) |-> (kind_o != scl_pkg::KindLineEnd), "line end before last result")
  // the second result of a pair follows the first
  `SCL_ASSERT_NEXT(a_pair_follows, out_valid_o && !last_o, out_valid_o, "second result lost")
  // at_eof only marks a line end
  `SCL_ASSERT(a_eof_on_line_end, (out_valid_o && at_eof_o) |-> (kind_o == scl_pkg::KindLineEnd), "at_eof off a line end")

endmodule

`default_nettype wire

// ----- hw/rtl/scl_lex_core.sv -----
// ----------------------------------------------------------------------------
// scl_lex_core
// lexer state and single-pass decode of one registered character
// ----------------------------------------------------------------------------
`default_nettype none

module scl_lex_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic [7:0]     char_i,
  input  wire logic           eof_i,
  output scl_pkg::pair_t      pair_o
);

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       op;
    logic             emit;
    scl_pkg::result_t res;
  } bw_t;

  logic [2:0] mode_q, mode_d;
  logic [7:0] op_q, op_d;
  bw_t        bw;
  logic       pair_op;

  // handling of a character between words
  function automatic bw_t between_words(logic [7:0] c, logic eof, logic [7:0] op);
    bw_t r;
    r.mode = scl_pkg::ModeStart;
    r.op   = op;
    r.emit = 1'b0;
    r.res  = scl_pkg::mk_result(scl_pkg::KindByte, c, 1'b0);
    if (eof) begin
      r.emit = 1'b1;
      r.res  = scl_pkg::mk_result(scl_pkg::KindLineEnd, 8'h00, 1'b1);
    end else if (c == scl_pkg::ChBackslash) begin
      r.mode = scl_pkg::ModeStartBs;
    end else if ((c == scl_pkg::ChSpace) || (c == scl_pkg::ChTab)) begin
      r.mode = scl_pkg::ModeStart;
    end else if (c == scl_pkg::ChNewline) begin
      r.emit = 1'b1;
      r.res  = scl_pkg::mk_result(scl_pkg::KindLineEnd, 8'h00, 1'b0);
    end else if (c == scl_pkg::ChHash) begin
      r.mode = scl_pkg::ModeComment;
    end else if (c == scl_pkg::ChQuote) begin
      r.mode = scl_pkg::ModeQuotes;
    end else if (scl_pkg::is_operator(c)) begin
      r.emit = 1'b1;
      r.op   = c;
      r.mode = scl_pkg::ModeOp;
    end else begin
      r.emit = 1'b1;
      r.mode = scl_pkg::ModeWord;
    end
    return r;
  endfunction

  assign bw      = between_words(char_i, eof_i, op_q);
  assign pair_op = !eof_i && (char_i == op_q) &&
                   ((char_i == scl_pkg::ChGt) || (char_i == scl_pkg::ChPipe) ||
                    (char_i == scl_pkg::ChAmp));

  always_comb begin
    scl_pkg::result_t byte_r, we_r;
    byte_r = scl_pkg::mk_result(scl_pkg::KindByte, char_i, 1'b0);
    we_r   = scl_pkg::mk_result(scl_pkg::KindWordEnd, 8'h00, 1'b0);
    mode_d      = mode_q;
    op_d        = op_q;
    pair_o.load = 1'b0;
    pair_o.two  = 1'b0;
    pair_o.res0 = byte_r;
    pair_o.res1 = bw.res;
    unique case (mode_q)
      scl_pkg::ModeStartBs: begin
        if (!eof_i && (char_i == scl_pkg::ChBackslash)) begin
          pair_o.load = 1'b1;
          mode_d      = scl_pkg::ModeWord;
        end else begin
          pair_o.load = bw.emit;
          pair_o.res0 = bw.res;
          mode_d      = bw.mode;
          op_d        = bw.op;
        end
      end
      scl_pkg::ModeWord: begin
        if (eof_i || scl_pkg::is_separator(char_i)) begin
          pair_o.load = 1'b1;
          pair_o.two  = bw.emit;
          pair_o.res0 = we_r;
          mode_d      = bw.mode;
          op_d        = bw.op;
        end else if (char_i == scl_pkg::ChBackslash) begin
          mode_d = scl_pkg::ModeWordBs;
        end else begin
          pair_o.load = 1'b1;
        end
      end
      scl_pkg::ModeWordBs: begin
        pair_o.load = 1'b1;
        if (eof_i) begin
          pair_o.two  = 1'b1;
          pair_o.res0 = we_r;
          mode_d      = bw.mode;
        end else begin
          mode_d = scl_pkg::ModeWord;
        end
      end
      scl_pkg::ModeQuotes: begin
        pair_o.load = 1'b1;
        if (eof_i) begin
          pair_o.two  = 1'b1;
          pair_o.res0 = we_r;
          mode_d      = bw.mode;
        end else if (char_i == scl_pkg::ChQuote) begin
          pair_o.res0 = we_r;
          mode_d      = scl_pkg::ModeStart;
        end
      end
      scl_pkg::ModeOp: begin
        pair_o.load = 1'b1;
        if (pair_op) begin
          pair_o.two  = 1'b1;
          pair_o.res1 = we_r;
          mode_d      = scl_pkg::ModeStart;
        end else begin
          pair_o.two  = bw.emit;
          pair_o.res0 = we_r;
          mode_d      = bw.mode;
          op_d        = bw.op;
        end
      end
      scl_pkg::ModeComment: begin
        if (eof_i || (char_i == scl_pkg::ChNewline)) begin
          pair_o.load = 1'b1;
          pair_o.res0 = scl_pkg::mk_result(scl_pkg::KindLineEnd, 8'h00, eof_i);
          mode_d      = scl_pkg::ModeStart;
        end
      end
      default: begin
        pair_o.load = bw.emit;
        pair_o.res0 = bw.res;
        mode_d      = bw.mode;
        op_d        = bw.op;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= scl_pkg::ModeStart;
      op_q   <= 8'h00;
    end else if (adv_i) begin
      mode_q <= mode_d;
      op_q   <= op_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scl_out_buf.sv -----
// ----------------------------------------------------------------------------
// scl_out_buf
// result register holding the one or two results of an item
// ----------------------------------------------------------------------------
`default_nettype none

module scl_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  scl_pkg::pair_t      pair_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          token_byte_o,
  output logic                at_eof_o,
  output logic                last_o
);

  logic             valid_q;
  logic             sel_q;
  logic             two_q;
  scl_pkg::result_t res0_q, res1_q;
  scl_pkg::result_t cur;
  logic             xfer;

  assign cur          = sel_q ? res1_q : res0_q;
  assign out_valid_o  = valid_q;
  assign kind_o       = cur.kind;
  assign token_byte_o = cur.token_byte;
  assign at_eof_o     = cur.at_eof;
  assign last_o       = !two_q || sel_q;
  assign xfer         = valid_q && !out_stall_i;
  assign free_o       = !valid_q || (xfer && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      two_q   <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
      two_q   <= pair_i.two;
    end else if (xfer) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res0_q <= pair_i.res0;
      res1_q <= pair_i.res1;
    end
  end

endmodule

`default_nettype wire

// ----- dv/shell_command_lexer_test.sv -----
// ----------------------------------------------------------------------------
// shell_command_lexer_test
// self-checking bench for the streaming shell lexer: a directed run through
// escapes, quotes, operators, comments and end of input, then randomised
// command-line fragments, with random idling on both sides and one long
// receiver hold-off; every result transfer is checked against a tokenizer
// model kept in the scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shell_command_lexer_test;
  import scl_pkg::*;

  typedef struct packed {
    result_t res;
    logic    last;
  } token_t;

  class token_scoreboard;
    logic [2:0] mode;
    logic [7:0] op_byte;
    token_t     step_tokens[$];
    token_t     expected_tokens[$];
    int         errors;

    function new();
      mode    = ModeStart;
      op_byte = 8'h00;
      errors  = 0;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void add_token(logic [1:0] kind, logic [7:0] b, logic eof);
      token_t t;
      t.res.kind       = kind;
      t.res.token_byte = b;
      t.res.at_eof     = eof;
      t.last           = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function logic is_op_byte(logic [7:0] c);
      return c inside {ChGt, ChPipe, ChAmp, ChLt, ChLParen, ChRParen, ChSemi};
    endfunction

    function logic is_sep_byte(logic [7:0] c);
      return (c inside {ChNewline, ChSpace, ChTab, ChQuote, ChHash}) || is_op_byte(c);
    endfunction

    // character seen with no word open
    function void lex_between(logic [7:0] c, logic eof);
      mode = ModeStart;
      if (eof) begin
        add_token(KindLineEnd, 8'h00, 1'b1);
      end else if (c == ChBackslash) begin
        mode = ModeStartBs;
      end else if (c == ChSpace || c == ChTab) begin
        mode = ModeStart;
      end else if (c == ChNewline) begin
        add_token(KindLineEnd, 8'h00, 1'b0);
      end else if (c == ChHash) begin
        mode = ModeComment;
      end else if (c == ChQuote) begin
        mode = ModeQuotes;
      end else if (is_op_byte(c)) begin
        add_token(KindByte, c, 1'b0);
        op_byte = c;
        mode    = ModeOp;
      end else begin
        add_token(KindByte, c, 1'b0);
        mode = ModeWord;
      end
    endfunction

    function void note_char(logic [7:0] c, logic eof);
      step_tokens.delete();
      case (mode)
        ModeStartBs: begin
          if (!eof && c == ChBackslash) begin
            add_token(KindByte, c, 1'b0);
            mode = ModeWord;
          end else begin
            lex_between(c, eof);
          end
        end
        ModeWord: begin
          if (eof || is_sep_byte(c)) begin
            add_token(KindWordEnd, 8'h00, 1'b0);
            lex_between(c, eof);
          end else if (c == ChBackslash) begin
            mode = ModeWordBs;
          end else begin
            add_token(KindByte, c, 1'b0);
          end
        end
        ModeWordBs: begin
          if (eof) begin
            add_token(KindWordEnd, 8'h00, 1'b0);
            lex_between(c, eof);
          end else begin
            add_token(KindByte, c, 1'b0);
            mode = ModeWord;
          end
        end
        ModeQuotes: begin
          if (eof) begin
            add_token(KindWordEnd, 8'h00, 1'b0);
            lex_between(c, eof);
          end else if (c == ChQuote) begin
            add_token(KindWordEnd, 8'h00, 1'b0);
            mode = ModeStart;
          end else begin
            add_token(KindByte, c, 1'b0);
          end
        end
        ModeOp: begin
          if (!eof && c == op_byte && (c inside {ChGt, ChPipe, ChAmp})) begin
            add_token(KindByte, c, 1'b0);
            add_token(KindWordEnd, 8'h00, 1'b0);
            mode = ModeStart;
          end else begin
            add_token(KindWordEnd, 8'h00, 1'b0);
            lex_between(c, eof);
          end
        end
        ModeComment: begin
          if (eof) begin
            add_token(KindLineEnd, 8'h00, 1'b1);
            mode = ModeStart;
          end else if (c == ChNewline) begin
            add_token(KindLineEnd, 8'h00, 1'b0);
            mode = ModeStart;
          end
        end
        default: lex_between(c, eof);
      endcase
      if (step_tokens.size() > 0) begin
        step_tokens[step_tokens.size() - 1].last = 1'b1;
      end
      foreach (step_tokens[i]) begin
        expected_tokens.push_back(step_tokens[i]);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] b, logic eof, logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        fail($sformatf("unexpected result kind %0d byte %02h eof %0b last %0b",
                       kind, b, eof, last));
        return;
      end
      want = expected_tokens.pop_front();
      if (kind !== want.res.kind || b !== want.res.token_byte ||
          eof !== want.res.at_eof || last !== want.last) begin
        fail($sformatf({"mismatch: expected kind %0d byte %02h eof %0b last %0b,",
                        " got kind %0d byte %02h eof %0b last %0b"},
                       want.res.kind, want.res.token_byte, want.res.at_eof, want.last,
                       kind, b, eof, last));
      end
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] char_code_i    = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] token_byte_o;
  logic       at_eof_o;
  logic       last_o;

  token_scoreboard sb = new();
  logic [8:0]      char_plan[$];
  int              items_sent   = 0;
  int              results_seen = 0;

  shell_command_lexer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .token_byte_o   (token_byte_o),
    .at_eof_o       (at_eof_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void plan(logic [7:0] c, logic eof);
    char_plan.push_back({eof, c});
  endfunction

  function automatic void plan_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      plan(s[i], 1'b0);
    end
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 6))
      0: return ChGt;
      1: return ChPipe;
      2: return ChAmp;
      3: return ChLt;
      4: return ChLParen;
      5: return ChRParen;
      default: return ChSemi;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] ofs;
    ofs = 8'($urandom_range(0, 25));
    return 8'h61 + ofs;
  endfunction

  // one fragment of a command line, mostly well formed
  function automatic void plan_fragment();
    int         r;
    int         n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          plan(ChBackslash, 1'b0);
          plan(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end else begin
          plan(pick_letter(), 1'b0);
        end
      end
    end else if (r < 45) begin
      plan($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0);
    end else if (r < 57) begin
      c = pick_operator();
      plan(c, 1'b0);
      if ($urandom_range(0, 1)) begin
        plan(c, 1'b0);
      end
    end else if (r < 65) begin
      plan(ChQuote, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        plan(c == ChQuote ? 8'h51 : c, 1'b0);
      end
      plan(ChQuote, $urandom_range(0, 9) == 0);
    end else if (r < 70) begin
      plan(ChHash, 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) begin
        plan(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
        plan(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        plan(ChNewline, 1'b0);
      end
    end else if (r < 75) begin
      plan(ChBackslash, 1'b0);
      plan($urandom_range(0, 1) ? ChBackslash : pick_letter(), 1'b0);
    end else if (r < 84) begin
      plan(ChNewline, 1'b0);
    end else if (r < 88) begin
      plan(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      plan(8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  task automatic send_item(logic [8:0] item);
    int gap;
    gap = (items_sent % 100 < 20) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= item[7:0];
    end_of_input_i <= item[8];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_char(item[7:0], item[8]);
    items_sent++;
  endtask

  task automatic send_plan();
    while (char_plan.size() > 0) begin
      send_item(char_plan.pop_front());
    end
  endtask

  initial begin
    int settle;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word bytes at both extremes, escaped newline, every operator and pairs
    plan(8'hff, 1'b0);
    plan(8'h00, 1'b0);
    plan_text("\\\n>>||&<();x");
    // backslash then end of input inside a word
    plan(ChBackslash, 1'b0);
    plan(8'hff, 1'b1);
    // double and lone backslash at word start, empty quotes, quotes cut by eof
    plan_text("\\\\ \\q\"\"\"z");
    plan(8'h00, 1'b1);
    // comments ended by newline and by eof, an empty line, ampersand pair
    plan_text("#k\n#");
    plan(8'h5a, 1'b1);
    plan_text("\n\t&&");
    plan(8'h3e, 1'b1);
    send_plan();

    while (items_sent < 530) begin
      plan_fragment();
      send_plan();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_tokens.size() > 0) begin
      @(posedge clk_i);
    end
    settle = 20;
    repeat (settle) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("shell_command_lexer_test: PASS");
    end else begin
      $display("shell_command_lexer_test: FAIL");
    end
    $finish;
  end

  // result side, with one long hold-off so the block backs up
  initial begin
    int gap;
    bit held_off;
    held_off = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held_off && results_seen >= 150) begin
        gap      = 80;
        held_off = 1'b1;
      end else if (results_seen % 100 >= 50 && results_seen % 100 < 70) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(kind_o, token_byte_o, at_eof_o, last_o);
      results_seen++;
    end
  end

  initial begin
    #200us;
    $display("shell_command_lexer_test: FAIL");
    $finish;
  end

endmodule
